// File: hdl/pse_pkg.sv
// shared constants, types and helper functions for the symmetric 2x2 eigenvalue pipeline
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    // fixed point format of the data words
    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;

    // differences, doubled off-diagonals and traces
    localparam int DIFF_W = DATA_W + 1;
    // tree split c2 = floor(sqrt(p*p + q*q))
    localparam int ROOT_W = DATA_W + 1;
    // radicand p*p + q*q
    localparam int RAD_W  = 2 * DIFF_W;
    // numerator of c4
    localparam int N4_W   = 2 * DIFF_W + 1;
    // divisor, up to twice the tree split
    localparam int DEN_W  = ROOT_W + 1;
    // quotient magnitude bits, saturation limit is 2^QB - 1
    localparam int QB     = FRAC_BITS + 23;
    localparam int QUOT_W = QB + 1;
    // numerators of c6 and c8
    localparam int NUM_W  = ((2 * QB > 68) ? 2 * QB : 68) + 2;
    // multiplier operand width for the numerator terms
    localparam int MUL_W  = DIFF_W + 1;
    // split of a quotient magnitude into partial product halves
    localparam int LO_W   = (QB + 1) / 2;
    localparam int HI_W   = QB - LO_W;
    // width of trace -/+ split before halving
    localparam int SUM_W  = QUOT_W + 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [MUL_W-1:0]  t_mul;

    // one input word, unpacked
    typedef struct packed {
        t_word a11;
        t_word a12;
        t_word a22;
        t_word b11;
        t_word b12;
        t_word b22;
        t_word d11;
        t_word d12;
        t_word d22;
        t_word e11;
        t_word e12;
        t_word e22;
    } t_in;

    // working set that travels down the pipeline
    typedef struct packed {
        logic signed [DIFF_W-1:0] p;
        logic signed [DIFF_W-1:0] q;
        logic signed [DIFF_W-1:0] r;
        logic signed [DIFF_W-1:0] s;
        logic signed [DIFF_W-1:0] u;
        logic signed [DIFF_W-1:0] v;
        logic signed [DIFF_W-1:0] w;
        logic signed [DIFF_W-1:0] z;
        logic signed [DIFF_W-1:0] c1;
        logic signed [DIFF_W-1:0] c3;
        logic signed [DIFF_W-1:0] c5;
        logic signed [DIFF_W-1:0] c7;
        logic [ROOT_W-1:0]        c2;
        logic signed [N4_W-1:0]   n4;
        logic signed [QUOT_W-1:0] c4;
        logic signed [QUOT_W-1:0] c6;
    } t_item;

    // floor of half, saturated to a data word
    function automatic t_word sat_half(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] h;
        logic signed [SUM_W-1:0] lim_hi;
        logic signed [SUM_W-1:0] lim_lo;
        t_word res;
        h      = x >>> 1;
        lim_hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lim_lo = ~lim_hi;
        if (h > lim_hi) begin
            res = lim_hi[DATA_W-1:0];
        end else if (h < lim_lo) begin
            res = lim_lo[DATA_W-1:0];
        end else begin
            res = h[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/perturbative_sym2x2_eigenvalues.sv
// Eigenvalues of a symmetric 2x2 matrix and its 1-, 2- and 3-loop corrections,
// signed Q7.24 in and out. One word is taken every clock unless the output
// stalls; the pipeline is 3 (front) + 33 (square root) + 3 * (FRAC_BITS + 25)
// (three dividers) + 2 * 3 (numerators) + 1 (output) stages deep, set by the
// one-bit-per-stage square root and dividers. When the output word is not
// taken the whole pipeline holds. A zero tree split raises tuser and
// forces the six correction fields to zero.
`timescale 1ns / 1ps
`default_nettype none

module perturbative_sym2x2_eigenvalues
    import pse_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tree_a11, tree_a12, tree_a22, one_loop_b11, one_loop_b12, one_loop_b22,
    // two_loop_d11, two_loop_d12, two_loop_d22, three_loop_e11, three_loop_e12,
    // three_loop_e22
    input  wire logic [383:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tree_low, tree_high, one_loop_low, one_loop_high, two_loop_low,
    // two_loop_high, three_loop_low, three_loop_high
    output logic [255:0]       m_axis_tdata,
    // degenerate
    output logic [0:0]         m_axis_tuser
);

    logic en;
    t_in  in_word;

    logic             f_v;
    t_item            f_item;
    logic [RAD_W-1:0] f_rad;

    logic              q_v;
    t_item             q_item_raw, q_item;
    logic [ROOT_W-1:0] q_root;

    logic                     d4_v, d6_v, d8_v;
    t_item                    d4_item_raw, d4_item, d6_item_raw, d6_item, d8_item;
    logic signed [QUOT_W-1:0] d4_quot, d6_quot, d8_quot;

    logic                    n6_v, n8_v;
    t_item                   n6_item, n8_item;
    logic signed [NUM_W-1:0] n6_num, n8_num;
    t_mul                    x6 [4], y6 [4], x8 [4], y8 [4];

    logic         r_out_v;
    logic [255:0] r_out_data;
    logic         r_out_deg;
    logic [255:0] n_out_data;
    logic         n_deg;

    // whole pipeline advances unless the output word is stuck
    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    // unpack input word, first field lowest
    always_comb begin
        in_word.a11 = s_axis_tdata[31:0];
        in_word.a12 = s_axis_tdata[63:32];
        in_word.a22 = s_axis_tdata[95:64];
        in_word.b11 = s_axis_tdata[127:96];
        in_word.b12 = s_axis_tdata[159:128];
        in_word.b22 = s_axis_tdata[191:160];
        in_word.d11 = s_axis_tdata[223:192];
        in_word.d12 = s_axis_tdata[255:224];
        in_word.d22 = s_axis_tdata[287:256];
        in_word.e11 = s_axis_tdata[319:288];
        in_word.e12 = s_axis_tdata[351:320];
        in_word.e22 = s_axis_tdata[383:352];
    end

    pse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_in    (in_word),
        .o_valid (f_v),
        .o_item  (f_item),
        .o_rad   (f_rad)
    );

    pse_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_item  (f_item),
        .i_rad   (f_rad),
        .o_valid (q_v),
        .o_item  (q_item_raw),
        .o_root  (q_root)
    );

    always_comb begin
        q_item    = q_item_raw;
        q_item.c2 = q_root;
    end

    // c4 = (p*r + q*s) / c2
    pse_div u_div4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_v),
        .i_item  (q_item),
        .i_num   (NUM_W'(q_item.n4)),
        .i_den   (DEN_W'(q_item.c2)),
        .o_valid (d4_v),
        .o_item  (d4_item_raw),
        .o_quot  (d4_quot)
    );

    always_comb begin
        d4_item    = d4_item_raw;
        d4_item.c4 = d4_quot;
    end

    // c6 numerator: r*r + s*s + 2p*u + 2q*v - c4*c4
    always_comb begin
        x6[0] = MUL_W'(d4_item.r);
        y6[0] = MUL_W'(d4_item.r);
        x6[1] = MUL_W'(d4_item.s);
        y6[1] = MUL_W'(d4_item.s);
        x6[2] = {d4_item.p, 1'b0};
        y6[2] = MUL_W'(d4_item.u);
        x6[3] = {d4_item.q, 1'b0};
        y6[3] = MUL_W'(d4_item.v);
    end

    pse_numer u_numer6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d4_v),
        .i_item  (d4_item),
        .i_x     (x6),
        .i_y     (y6),
        .i_g     (d4_item.c4),
        .i_h     (d4_item.c4),
        .o_valid (n6_v),
        .o_item  (n6_item),
        .o_num   (n6_num)
    );

    pse_div u_div6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n6_v),
        .i_item  (n6_item),
        .i_num   (n6_num),
        .i_den   ({n6_item.c2, 1'b0}),
        .o_valid (d6_v),
        .o_item  (d6_item_raw),
        .o_quot  (d6_quot)
    );

    always_comb begin
        d6_item    = d6_item_raw;
        d6_item.c6 = d6_quot;
    end

    // c8 numerator: r*u + s*v + p*w + q*z - c4*c6
    always_comb begin
        x8[0] = MUL_W'(d6_item.r);
        y8[0] = MUL_W'(d6_item.u);
        x8[1] = MUL_W'(d6_item.s);
        y8[1] = MUL_W'(d6_item.v);
        x8[2] = MUL_W'(d6_item.p);
        y8[2] = MUL_W'(d6_item.w);
        x8[3] = MUL_W'(d6_item.q);
        y8[3] = MUL_W'(d6_item.z);
    end

    pse_numer u_numer8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d6_v),
        .i_item  (d6_item),
        .i_x     (x8),
        .i_y     (y8),
        .i_g     (d6_item.c4),
        .i_h     (d6_item.c6),
        .o_valid (n8_v),
        .o_item  (n8_item),
        .o_num   (n8_num)
    );

    pse_div u_div8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n8_v),
        .i_item  (n8_item),
        .i_num   (n8_num),
        .i_den   (DEN_W'(n8_item.c2)),
        .o_valid (d8_v),
        .o_item  (d8_item),
        .o_quot  (d8_quot)
    );

    // halve trace -/+ split, saturate, zero corrections on a degenerate split
    always_comb begin
        logic signed [SUM_W-1:0] c2s;
        c2s   = $signed(SUM_W'(d8_item.c2));
        n_deg = (d8_item.c2 == '0);
        n_out_data          = '0;
        n_out_data[31:0]    = sat_half(SUM_W'(d8_item.c1) - c2s);
        n_out_data[63:32]   = sat_half(SUM_W'(d8_item.c1) + c2s);
        if (!n_deg) begin
            n_out_data[95:64]   = sat_half(SUM_W'(d8_item.c3) - SUM_W'(d8_item.c4));
            n_out_data[127:96]  = sat_half(SUM_W'(d8_item.c3) + SUM_W'(d8_item.c4));
            n_out_data[159:128] = sat_half(SUM_W'(d8_item.c5) - SUM_W'(d8_item.c6));
            n_out_data[191:160] = sat_half(SUM_W'(d8_item.c5) + SUM_W'(d8_item.c6));
            n_out_data[223:192] = sat_half(SUM_W'(d8_item.c7) - SUM_W'(d8_quot));
            n_out_data[255:224] = sat_half(SUM_W'(d8_item.c7) + SUM_W'(d8_quot));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_deg  <= n_deg;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_deg;

endmodule

`default_nettype wire

// File: hdl/pse_front.sv
// front stages: differences, traces, squared tree split and c4 numerator
`timescale 1ns / 1ps
`default_nettype none

module pse_front
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_in               i_in,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [RAD_W-1:0]       o_rad
);

    t_item n_item1;
    t_item n_item3;
    logic  r_v1, r_v2, r_v3;
    t_item r_item1, r_item2, r_item3;
    logic signed [2*DIFF_W-1:0] r_pp, r_qq, r_pr, r_qs;
    logic [RAD_W-1:0] r_rad;

    // differences, doubled off-diagonals and traces
    always_comb begin
        n_item1    = '0;
        n_item1.p  = DIFF_W'(i_in.a11) - DIFF_W'(i_in.a22);
        n_item1.q  = {i_in.a12, 1'b0};
        n_item1.r  = DIFF_W'(i_in.b11) - DIFF_W'(i_in.b22);
        n_item1.s  = {i_in.b12, 1'b0};
        n_item1.u  = DIFF_W'(i_in.d11) - DIFF_W'(i_in.d22);
        n_item1.v  = {i_in.d12, 1'b0};
        n_item1.w  = DIFF_W'(i_in.e11) - DIFF_W'(i_in.e22);
        n_item1.z  = {i_in.e12, 1'b0};
        n_item1.c1 = DIFF_W'(i_in.a11) + DIFF_W'(i_in.a22);
        n_item1.c3 = DIFF_W'(i_in.b11) + DIFF_W'(i_in.b22);
        n_item1.c5 = DIFF_W'(i_in.d11) + DIFF_W'(i_in.d22);
        n_item1.c7 = DIFF_W'(i_in.e11) + DIFF_W'(i_in.e22);
    end

    // c4 numerator joins the working set
    always_comb begin
        n_item3    = r_item2;
        n_item3.n4 = N4_W'(r_pr) + N4_W'(r_qs);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // products, then sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= n_item1;
            r_item2 <= r_item1;
            r_pp    <= r_item1.p * r_item1.p;
            r_qq    <= r_item1.q * r_item1.q;
            r_pr    <= r_item1.p * r_item1.r;
            r_qs    <= r_item1.q * r_item1.s;
            r_item3 <= n_item3;
            r_rad   <= RAD_W'(r_pp + r_qq);
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;
    assign o_rad   = r_rad;

endmodule

`default_nettype wire

// File: hdl/pse_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module pse_sqrt
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_item             i_item,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int TRIAL_W = RAD_W + 2;

    logic              r_v    [ROOT_W];
    t_item             r_item [ROOT_W];
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic               v_in;
        t_item              item_in;
        logic [TRIAL_W-1:0] rem_in;
        logic [TRIAL_W-1:0] trial;
        logic [ROOT_W-1:0]  root_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign item_in = i_item;
            assign rem_in  = TRIAL_W'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign item_in = r_item[k-1];
            assign rem_in  = TRIAL_W'(r_rem[k-1]);
            assign root_in = r_root[k-1];
        end

        // (root + 2^b)^2 - root^2
        assign trial = (TRIAL_W'(root_in) << (B + 1)) + (TRIAL_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        // try this root bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= item_in;
                if (rem_in >= trial) begin
                    r_rem[k]  <= RAD_W'(rem_in - trial);
                    r_root[k] <= root_in | (ROOT_W'(1) << B);
                end else begin
                    r_rem[k]  <= RAD_W'(rem_in);
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_item  = r_item[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// File: hdl/pse_div.sv
// pipelined signed by unsigned restoring divider with saturated quotient
`timescale 1ns / 1ps
`default_nettype none

module pse_div
    import pse_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire t_item                   i_item,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic                         o_valid,
    output t_item                        o_item,
    output logic signed [QUOT_W-1:0]     o_quot
);

    localparam int CMP_W = NUM_W + DEN_W;

    logic [NUM_W-1:0] n_mag;
    logic             n_ovf;

    logic             r_v    [QB+1];
    t_item            r_item [QB+1];
    logic             r_neg  [QB+1];
    logic             r_ovf  [QB+1];
    logic [DEN_W-1:0] r_den  [QB+1];
    logic [DEN_W-1:0] r_rem  [QB+1];
    logic [QB-1:0]    r_lq   [QB+1];

    logic                     r_out_v;
    t_item                    r_out_item;
    logic signed [QUOT_W-1:0] r_quot;
    logic [QB-1:0]            n_qm;

    // magnitude and overflow check: quotient saturates when num >= den * 2^QB
    always_comb begin
        n_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_ovf = CMP_W'(n_mag) >= (CMP_W'(i_den) << QB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            r_neg[0]  <= i_num[NUM_W-1];
            r_ovf[0]  <= n_ovf;
            r_den[0]  <= i_den;
            r_rem[0]  <= n_mag[QB +: DEN_W];
            r_lq[0]   <= n_mag[QB-1:0];
        end
    end

    // one quotient bit per stage, numerator bits shift out as quotient bits shift in
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [DEN_W:0] t;
        logic           ge;

        assign t  = {r_rem[k-1], r_lq[k-1][QB-1]};
        assign ge = t >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k] <= r_item[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_den[k]  <= r_den[k-1];
                r_rem[k]  <= ge ? DEN_W'(t - {1'b0, r_den[k-1]}) : DEN_W'(t);
                r_lq[k]   <= {r_lq[k-1][QB-2:0], ge};
            end
        end
    end

    // saturate and restore sign
    assign n_qm = r_ovf[QB] ? {QB{1'b1}} : r_lq[QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_item <= r_item[QB];
            r_quot     <= r_neg[QB] ? -$signed({1'b0, n_qm}) : $signed({1'b0, n_qm});
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out_item;
    assign o_quot  = r_quot;

endmodule

`default_nettype wire

// File: hdl/pse_numer.sv
// numerator x0*y0 + x1*y1 + x2*y2 + x3*y3 - g*h over three stages
`timescale 1ns / 1ps
`default_nettype none

module pse_numer
    import pse_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire t_item                    i_item,
    input  wire t_mul                     i_x [4],
    input  wire t_mul                     i_y [4],
    input  wire logic signed [QUOT_W-1:0] i_g,
    input  wire logic signed [QUOT_W-1:0] i_h,
    output logic                          o_valid,
    output t_item                         o_item,
    output logic signed [NUM_W-1:0]       o_num
);

    localparam int GH_W = 2 * QB;

    logic [QB-1:0] n_gm, n_hm;

    logic  r_v1, r_v2, r_v3;
    t_item r_item1, r_item2, r_item3;
    logic signed [2*MUL_W-1:0] r_prod [4];
    logic [2*LO_W-1:0]      r_pll;
    logic [LO_W+HI_W-1:0]   r_plh, r_phl;
    logic [2*HI_W-1:0]      r_phh;
    logic                   r_neg1, r_neg2;
    logic signed [NUM_W-1:0] r_sum01, r_sum23, r_num;
    logic [GH_W-1:0]        r_gh;
    logic signed [NUM_W-1:0] n_gh;

    // magnitudes of g and h fit QB bits since both are saturated quotients
    always_comb begin
        n_gm = i_g[QUOT_W-1] ? QB'(-i_g) : QB'(i_g);
        n_hm = i_h[QUOT_W-1] ? QB'(-i_h) : QB'(i_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // products and partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= i_item;
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= i_x[j] * i_y[j];
            end
            r_pll  <= n_gm[LO_W-1:0] * n_hm[LO_W-1:0];
            r_plh  <= n_gm[LO_W-1:0] * n_hm[QB-1:LO_W];
            r_phl  <= n_gm[QB-1:LO_W] * n_hm[LO_W-1:0];
            r_phh  <= n_gm[QB-1:LO_W] * n_hm[QB-1:LO_W];
            r_neg1 <= i_g[QUOT_W-1] ^ i_h[QUOT_W-1];
        end
    end

    // pairwise sums and the g*h magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item2 <= r_item1;
            r_sum01 <= NUM_W'(r_prod[0]) + NUM_W'(r_prod[1]);
            r_sum23 <= NUM_W'(r_prod[2]) + NUM_W'(r_prod[3]);
            r_gh    <= (GH_W'(r_phh) << (2 * LO_W))
                     + ((GH_W'(r_plh) + GH_W'(r_phl)) << LO_W)
                     + GH_W'(r_pll);
            r_neg2  <= r_neg1;
        end
    end

    // final sum
    assign n_gh = $signed(NUM_W'(r_gh));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item3 <= r_item2;
            r_num   <= r_sum01 + r_sum23 - (r_neg2 ? -n_gh : n_gh);
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;
    assign o_num   = r_num;

endmodule

`default_nettype wire
